// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the job scheduler RTL.
// Included by the top level; relies on aclk and aresetn in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/mjs_pkg.sv =====
// Shared types, codes and the queue ordering function of the job scheduler.
// No dependencies; used by multicore_job_scheduler_core.
`default_nettype none

package mjs_pkg;

    localparam int MAX_CORES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [2:0] MODE_FCFS = 3'd0;
    localparam logic [2:0] MODE_SJF  = 3'd1;
    localparam logic [2:0] MODE_PSJF = 3'd2;
    localparam logic [2:0] MODE_PRI  = 3'd3;
    localparam logic [2:0] MODE_PPRI = 3'd4;
    localparam logic [2:0] MODE_RR   = 3'd5;

    localparam logic [1:0] FUNC_ARRIVE = 2'd0;
    localparam logic [1:0] FUNC_FINISH = 2'd1;
    localparam logic [1:0] FUNC_EXPIRE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    localparam logic signed [16:0] PICK_NONE    = -17'sd1;
    localparam logic signed [16:0] PICK_REFUSED = -17'sd2;

    localparam logic CFG_MODE  = 1'b0;
    localparam logic CFG_CORES = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] arrival;
        logic [23:0] remaining;
        logic [7:0]  prio;
        logic [31:0] wait_time;
        logic [31:0] response;
        logic [31:0] turnaround;
        logic        started;
    } job_t;

    // True when job a goes strictly ahead of job b in queue order.
    function automatic logic ahead(logic [2:0] mode, job_t a, job_t b);
        logic [31:0] ka;
        logic [31:0] kb;
        logic        r;
        case (mode)
            MODE_SJF, MODE_PSJF: begin
                ka = {8'd0, a.remaining};
                kb = {8'd0, b.remaining};
            end
            MODE_PRI, MODE_PPRI: begin
                ka = {24'd0, a.prio};
                kb = {24'd0, b.prio};
            end
            default: begin
                ka = a.arrival;
                kb = b.arrival;
            end
        endcase
        if (mode == MODE_RR) begin
            r = 1'b0;
        end else if (ka != kb) begin
            r = ka < kb;
        end else begin
            r = a.arrival < b.arrival;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/multicore_job_scheduler_core.sv =====
// Multicore job scheduler: per-core job state, sorted ready queue memory, sequencer.
// Depends on mjs_pkg and assert_macros.svh.
//
// Usage: the s_ channel takes one scheduler request (arrival, finish or quantum
// expiry, stamped with s_now); the m_ channel returns exactly one result per
// request: the core or job picked, a status code, the three time sums, the
// arrival count and the ready queue fill. cfg_we/cfg_addr/cfg_wdata write the
// mode (index 0) and the core count (index 1) while the block is idle.
// Sequencing: one shared subtract/compare unit walks the cores one per cycle and
// then the ready queue memory entry by entry (read, then write). A request may
// then run the preemption scan over the cores, and a dequeue and a sorted
// insertion in the ready queue. One request at a time.
// s_ready is high only while the sequencer is idle.
// Reset: synchronous, active low; clears all cores to idle, empties the queue,
// clears the sums and the arrival count, mode FCFS and one core.
// Stall: the result sits in an output register; a new request is taken while
// it waits, and the sequencer holds its next result until m_ready frees it.
`default_nettype none

module multicore_job_scheduler_core #(
    parameter int MAX_CORES   = mjs_pkg::MAX_CORES_DEF,
    parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_addr,
    input  wire logic [3:0]         cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [15:0]        s_job_id,
    input  wire logic [31:0]        s_now,
    input  wire logic [23:0]        s_run_length,
    input  wire logic [7:0]         s_prio,
    input  wire logic [2:0]         s_core_sel,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [16:0]      m_pick,
    output logic [1:0]              m_status,
    output logic [47:0]             m_sum_turnaround,
    output logic [47:0]             m_sum_waiting,
    output logic [47:0]             m_sum_response,
    output logic [31:0]             m_jobs_arrived,
    output logic [6:0]              m_queue_count
);

`include "assert_macros.svh"

    localparam int CIW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int NW  = $clog2(MAX_CORES + 1);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_AGE_C    = 5'd1;
    localparam logic [4:0] S_AGEQ_RD  = 5'd2;
    localparam logic [4:0] S_AGEQ_WR  = 5'd3;
    localparam logic [4:0] S_DECIDE   = 5'd4;
    localparam logic [4:0] S_WORST    = 5'd5;
    localparam logic [4:0] S_PRE_CMP  = 5'd6;
    localparam logic [4:0] S_CHK      = 5'd7;
    localparam logic [4:0] S_HEAD_RD  = 5'd8;
    localparam logic [4:0] S_HEAD_CMP = 5'd9;
    localparam logic [4:0] S_DQ_RD    = 5'd10;
    localparam logic [4:0] S_DQ_HEAD  = 5'd11;
    localparam logic [4:0] S_DN_RD    = 5'd12;
    localparam logic [4:0] S_DN_WR    = 5'd13;
    localparam logic [4:0] S_INS      = 5'd14;
    localparam logic [4:0] S_FIND_RD  = 5'd15;
    localparam logic [4:0] S_FIND_CMP = 5'd16;
    localparam logic [4:0] S_UP_RD    = 5'd17;
    localparam logic [4:0] S_UP_WR    = 5'd18;
    localparam logic [4:0] S_INS_WR   = 5'd19;
    localparam logic [4:0] S_FIN      = 5'd20;

    // control registers
    logic [4:0]           state_reg, state_next;
    logic [2:0]           mode_reg;
    logic [3:0]           cores_reg;
    logic [MAX_CORES-1:0] busy_reg, busy_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [31:0]          last_reg, last_next;
    logic [47:0]          tacc_reg, tacc_next;
    logic [47:0]          wacc_reg, wacc_next;
    logic [47:0]          racc_reg, racc_next;
    logic [31:0]          arr_reg, arr_next;
    logic                 m_valid_reg, m_valid_next;

    // working registers
    logic [1:0]           func_reg, func_next;
    logic [31:0]          now_reg, now_next;
    logic [31:0]          el_reg, el_next;
    logic [2:0]           csel_reg, csel_next;
    logic                 c_ok_reg, c_ok_next;
    logic                 do_ins_reg, do_ins_next;
    mjs_pkg::job_t        job_reg, job_next;
    mjs_pkg::job_t        wj_reg, wj_next;
    mjs_pkg::job_t        cur_reg, cur_next;
    mjs_pkg::job_t        ins_reg, ins_next;
    logic [CIW-1:0]       cptr_reg, cptr_next;
    logic [CIW-1:0]       w_reg, w_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic signed [16:0]   pick_reg, pick_next;
    logic [1:0]           stat_reg, stat_next;

    // output registers
    logic signed [16:0]   o_pick_reg, o_pick_next;
    logic [1:0]           o_stat_reg, o_stat_next;
    logic [47:0]          o_tacc_reg, o_tacc_next;
    logic [47:0]          o_wacc_reg, o_wacc_next;
    logic [47:0]          o_racc_reg, o_racc_next;
    logic [31:0]          o_arr_reg, o_arr_next;
    logic [CW-1:0]        o_cnt_reg, o_cnt_next;

    // core storage, one read port at cptr_reg
    mjs_pkg::job_t        core_mem [MAX_CORES];
    logic                 core_we;
    logic [CIW-1:0]       core_waddr;
    mjs_pkg::job_t        core_wdata;
    mjs_pkg::job_t        core_rd;

    // ready queue memory
    mjs_pkg::job_t        qmem [QUEUE_DEPTH];
    mjs_pkg::job_t        rdata_reg;
    logic                 q_we;
    logic [QAW-1:0]       q_waddr;
    mjs_pkg::job_t        q_wdata;
    logic [CW-1:0]        q_raddr_full;

    logic [NW-1:0]        lim;
    logic                 last_core;
    logic                 free_found;
    logic [CIW-1:0]       free_idx;
    mjs_pkg::job_t        aged;
    logic [32:0]          wsum;
    mjs_pkg::job_t        head;

    assign core_rd = core_mem[cptr_reg];
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        if (cores_reg == 4'd0) begin
            lim = NW'(1);
        end else if (32'(cores_reg) > 32'(MAX_CORES)) begin
            lim = NW'(MAX_CORES);
        end else begin
            lim = NW'(cores_reg);
        end
        last_core = (cptr_reg == CIW'(lim - NW'(1)));
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < MAX_CORES; i++) begin
            if (!free_found && !busy_reg[i] && (32'(i) < 32'(lim))) begin
                free_found = 1'b1;
                free_idx   = CIW'(i);
            end
        end
    end

    // shared aging unit: one core per cycle
    always_comb begin
        aged = core_rd;
        if (busy_reg[cptr_reg] && (core_rd.remaining != 24'd0)) begin
            if ({8'd0, core_rd.remaining} > el_reg) begin
                aged.remaining = core_rd.remaining - el_reg[23:0];
            end else begin
                aged.remaining = 24'd0;
                aged.turnaround = now_reg - core_rd.arrival;
            end
        end
    end

    assign wsum = {1'b0, rdata_reg.wait_time} + {1'b0, el_reg};

    always_comb begin
        head = rdata_reg;
        if (!rdata_reg.started) begin
            head.started  = 1'b1;
            head.response = now_reg - rdata_reg.arrival;
        end
    end

    always_comb begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        tacc_next    = tacc_reg;
        wacc_next    = wacc_reg;
        racc_next    = racc_reg;
        arr_next     = arr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        func_next    = func_reg;
        now_next     = now_reg;
        el_next      = el_reg;
        csel_next    = csel_reg;
        c_ok_next    = c_ok_reg;
        do_ins_next  = do_ins_reg;
        job_next     = job_reg;
        wj_next      = wj_reg;
        cur_next     = cur_reg;
        ins_next     = ins_reg;
        cptr_next    = cptr_reg;
        w_next       = w_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        pick_next    = pick_reg;
        stat_next    = stat_reg;
        o_pick_next  = o_pick_reg;
        o_stat_next  = o_stat_reg;
        o_tacc_next  = o_tacc_reg;
        o_wacc_next  = o_wacc_reg;
        o_racc_next  = o_racc_reg;
        o_arr_next   = o_arr_reg;
        o_cnt_next   = o_cnt_reg;
        core_we      = 1'b0;
        core_waddr   = cptr_reg;
        core_wdata   = aged;
        q_we         = 1'b0;
        q_waddr      = k_reg[QAW-1:0];
        q_wdata      = rdata_reg;
        q_raddr_full = k_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next  = s_func;
                    now_next   = s_now;
                    csel_next  = s_core_sel;
                    el_next    = (s_now >= last_reg) ? (s_now - last_reg) : 32'd0;
                    pick_next  = mjs_pkg::PICK_NONE;
                    stat_next  = mjs_pkg::STAT_OK;
                    do_ins_next = 1'b0;
                    job_next.id         = s_job_id;
                    job_next.arrival    = s_now;
                    job_next.remaining  = s_run_length;
                    job_next.prio       = s_prio;
                    job_next.wait_time  = 32'd0;
                    job_next.response   = 32'd0;
                    job_next.turnaround = 32'd0;
                    job_next.started    = 1'b1;
                    cptr_next = '0;
                    if (s_func == 2'd3) begin
                        state_next = S_FIN;
                    end else begin
                        last_next  = s_now;
                        state_next = S_AGE_C;
                    end
                end
            end
            S_AGE_C: begin
                core_we = 1'b1;
                if (last_core) begin
                    k_next     = '0;
                    state_next = (cnt_reg == '0) ? S_DECIDE : S_AGEQ_RD;
                end else begin
                    cptr_next = cptr_reg + CIW'(1);
                end
            end
            S_AGEQ_RD: begin
                state_next = S_AGEQ_WR;
            end
            S_AGEQ_WR: begin
                q_we    = 1'b1;
                q_wdata = rdata_reg;
                q_wdata.wait_time = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
                if (k_reg == cnt_reg - CW'(1)) begin
                    state_next = S_DECIDE;
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_AGEQ_RD;
                end
            end
            S_DECIDE: begin
                if (func_reg == mjs_pkg::FUNC_ARRIVE) begin
                    arr_next = arr_reg + 32'd1;
                    if (free_found) begin
                        core_we    = 1'b1;
                        core_waddr = free_idx;
                        core_wdata = job_reg;
                        busy_next[free_idx] = 1'b1;
                        pick_next  = 17'(free_idx);
                        state_next = S_FIN;
                    end else if (32'(cnt_reg) >= 32'(QUEUE_DEPTH)) begin
                        stat_next  = mjs_pkg::STAT_FULL;
                        state_next = S_FIN;
                    end else if (mode_reg == mjs_pkg::MODE_PSJF ||
                                 mode_reg == mjs_pkg::MODE_PPRI) begin
                        cptr_next  = '0;
                        state_next = S_WORST;
                    end else begin
                        ins_next         = job_reg;
                        ins_next.started = 1'b0;
                        state_next       = S_INS;
                    end
                end else begin
                    cptr_next  = CIW'(csel_reg);
                    c_ok_next  = 32'(csel_reg) < 32'(lim);
                    state_next = S_CHK;
                end
            end
            S_WORST: begin
                // later position wins ties: keep any core not strictly ahead
                if (cptr_reg == '0 || !mjs_pkg::ahead(mode_reg, core_rd, wj_reg)) begin
                    wj_next = core_rd;
                    w_next  = cptr_reg;
                end
                if (last_core) begin
                    state_next = S_PRE_CMP;
                end else begin
                    cptr_next = cptr_reg + CIW'(1);
                end
            end
            S_PRE_CMP: begin
                if (mjs_pkg::ahead(mode_reg, job_reg, wj_reg)) begin
                    core_we    = 1'b1;
                    core_waddr = w_reg;
                    core_wdata = job_reg;
                    ins_next   = wj_reg;
                    pick_next  = 17'(w_reg);
                end else begin
                    ins_next         = job_reg;
                    ins_next.started = 1'b0;
                end
                state_next = S_INS;
            end
            S_CHK: begin
                if (!c_ok_reg || !busy_reg[cptr_reg]) begin
                    state_next = S_FIN;
                end else if (core_rd.remaining == 24'd0) begin
                    tacc_next = tacc_reg + 48'(core_rd.turnaround);
                    wacc_next = wacc_reg + 48'(core_rd.wait_time);
                    racc_next = racc_reg + 48'(core_rd.response);
                    busy_next[cptr_reg] = 1'b0;
                    state_next = (cnt_reg == '0) ? S_FIN : S_DQ_RD;
                end else if (func_reg == mjs_pkg::FUNC_FINISH) begin
                    pick_next  = mjs_pkg::PICK_REFUSED;
                    stat_next  = mjs_pkg::STAT_REFUSED;
                    state_next = S_FIN;
                end else begin
                    cur_next = core_rd;
                    if (cnt_reg == '0) begin
                        pick_next  = 17'(core_rd.id);
                        state_next = S_FIN;
                    end else begin
                        state_next = S_HEAD_RD;
                    end
                end
            end
            S_HEAD_RD: begin
                q_raddr_full = '0;
                state_next   = S_HEAD_CMP;
            end
            S_HEAD_CMP: begin
                if (mjs_pkg::ahead(mode_reg, cur_reg, rdata_reg)) begin
                    pick_next  = 17'(cur_reg.id);
                    state_next = S_FIN;
                end else begin
                    ins_next    = cur_reg;
                    do_ins_next = 1'b1;
                    state_next  = S_DQ_RD;
                end
            end
            S_DQ_RD: begin
                q_raddr_full = '0;
                state_next   = S_DQ_HEAD;
            end
            S_DQ_HEAD: begin
                core_we    = 1'b1;
                core_wdata = head;
                busy_next[cptr_reg] = 1'b1;
                pick_next  = 17'(head.id);
                k_next     = '0;
                if (cnt_reg == CW'(1)) begin
                    cnt_next   = '0;
                    state_next = do_ins_reg ? S_INS : S_FIN;
                end else begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD: begin
                q_raddr_full = k_reg + CW'(1);
                state_next   = S_DN_WR;
            end
            S_DN_WR: begin
                q_we = 1'b1;
                if (k_reg == cnt_reg - CW'(2)) begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = do_ins_reg ? S_INS : S_FIN;
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_DN_RD;
                end
            end
            S_INS: begin
                k_next   = '0;
                pos_next = '0;
                state_next = (cnt_reg == '0) ? S_INS_WR : S_FIND_RD;
            end
            S_FIND_RD: begin
                state_next = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                if (mjs_pkg::ahead(mode_reg, ins_reg, rdata_reg)) begin
                    pos_next   = k_reg;
                    k_next     = cnt_reg;
                    state_next = S_UP_RD;
                end else if (k_reg == cnt_reg - CW'(1)) begin
                    pos_next   = cnt_reg;
                    state_next = S_INS_WR;
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_UP_RD: begin
                q_raddr_full = k_reg - CW'(1);
                state_next   = S_UP_WR;
            end
            S_UP_WR: begin
                // move one entry up toward the tail
                q_we = 1'b1;
                if (k_reg - CW'(1) == pos_reg) begin
                    state_next = S_INS_WR;
                end else begin
                    k_next     = k_reg - CW'(1);
                    state_next = S_UP_RD;
                end
            end
            S_INS_WR: begin
                q_we       = 1'b1;
                q_waddr    = pos_reg[QAW-1:0];
                q_wdata    = ins_reg;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    o_pick_next  = pick_reg;
                    o_stat_next  = stat_reg;
                    o_tacc_next  = tacc_reg;
                    o_wacc_next  = wacc_reg;
                    o_racc_next  = racc_reg;
                    o_arr_next   = arr_reg;
                    o_cnt_next   = cnt_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= mjs_pkg::MODE_FCFS;
            cores_reg   <= 4'd1;
            busy_reg    <= '0;
            cnt_reg     <= '0;
            last_reg    <= '0;
            tacc_reg    <= '0;
            wacc_reg    <= '0;
            racc_reg    <= '0;
            arr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            tacc_reg    <= tacc_next;
            wacc_reg    <= wacc_next;
            racc_reg    <= racc_next;
            arr_reg     <= arr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    mjs_pkg::CFG_MODE:  mode_reg  <= cfg_wdata[2:0];
                    mjs_pkg::CFG_CORES: cores_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        now_reg     <= now_next;
        el_reg      <= el_next;
        csel_reg    <= csel_next;
        c_ok_reg    <= c_ok_next;
        do_ins_reg  <= do_ins_next;
        job_reg     <= job_next;
        wj_reg      <= wj_next;
        cur_reg     <= cur_next;
        ins_reg     <= ins_next;
        cptr_reg    <= cptr_next;
        w_reg       <= w_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        pick_reg    <= pick_next;
        stat_reg    <= stat_next;
        o_pick_reg  <= o_pick_next;
        o_stat_reg  <= o_stat_next;
        o_tacc_reg  <= o_tacc_next;
        o_wacc_reg  <= o_wacc_next;
        o_racc_reg  <= o_racc_next;
        o_arr_reg   <= o_arr_next;
        o_cnt_reg   <= o_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (core_we) begin
            core_mem[core_waddr] <= core_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            qmem[q_waddr] <= q_wdata;
        end
        rdata_reg <= qmem[q_raddr_full[QAW-1:0]];
    end

    assign m_valid          = m_valid_reg;
    assign m_pick           = o_pick_reg;
    assign m_status         = o_stat_reg;
    assign m_sum_turnaround = o_tacc_reg;
    assign m_sum_waiting    = o_wacc_reg;
    assign m_sum_response   = o_racc_reg;
    assign m_jobs_arrived   = o_arr_reg;
    assign m_queue_count    = 7'(o_cnt_reg);

    `ASSERT_ALWAYS(a_cnt_bound, (32'(cnt_reg) <= 32'(QUEUE_DEPTH)), "queue fill above depth")
    `ASSERT_CLK(a_busy_after_accept, (s_valid && s_ready) |=> (state_reg != S_IDLE), "request accepted but sequencer idle")
    `ASSERT_CLK(a_fin_loads, (state_reg == S_FIN && (!m_valid || m_ready)) |=> (m_valid && state_reg == S_IDLE), "result not loaded")
    `ASSERT_CLK(a_ins_room, (state_reg == S_INS) |-> (32'(cnt_reg) < 32'(QUEUE_DEPTH)), "insert into full queue")

endmodule

`default_nettype wire
